// ----- rtl/core/clutx_pkg.sv -----
// ----------------------------------------------------------------------------
// clutx_pkg
// shared types, codes and color conversion for the palette pixel expander
// ----------------------------------------------------------------------------
package clutx_pkg;

    // input commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_NEW   = 2'd2;

    // pixel modes
    localparam logic [1:0] MODE_4BPP  = 2'd0;
    localparam logic [1:0] MODE_8BPP  = 2'd1;
    localparam logic [1:0] MODE_16BPP = 2'd2;

    // job kinds passed from front to back
    localparam logic [1:0] JOB_WRITE  = 2'd0;
    localparam logic [1:0] JOB_LOOKUP = 2'd1;
    localparam logic [1:0] JOB_DIRECT = 2'd2;

    // widest palette address the job format carries
    localparam int JOB_ADDR_W = 16;

    typedef struct packed {
        logic [1:0]            kind;
        logic [JOB_ADDR_W-1:0] addr;
        logic [15:0]           data;
        logic                  last;
    } job_t;

    // 1:5:5:5 to 8:8:8:8, all-zero word becomes transparent black
    function automatic logic [31:0] expand_color(input logic [15:0] c);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        logic [7:0] a;
        r = c[4:0];
        g = c[9:5];
        b = c[14:10];
        a = (c == 16'h0000) ? 8'h00 : 8'hFF;
        return {a, b, b[4:2], g, g[4:2], r, r[4:2]};
    endfunction

endpackage

// ----- rtl/core/clutx_front.sv -----
// ----------------------------------------------------------------------------
// clutx_front
// accepts items, tracks the pixel budget and splits them into jobs
// ----------------------------------------------------------------------------
module clutx_front
    import clutx_pkg::*;
#(
    parameter int PALETTE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [9:0]  entry_index,
    input  logic [15:0] entry_color,
    input  logic [15:0] pixel_data,
    input  logic [1:0]  pixel_mode,
    input  logic [7:0]  palette_row,
    input  logic [10:0] palette_entries,
    input  logic [23:0] pixel_count,
    output logic        push,
    output job_t        push_job,
    input  logic        q_full
);

    logic        pend_valid_reg;
    logic        pend_valid_next;
    job_t        pend_job_reg;
    job_t        pend_job_next;
    logic [23:0] emitted_reg;
    logic [23:0] emitted_next;

    logic        accept;
    logic [10:0] live;
    logic [6:0]  rows4;
    logic [6:0]  pr4;
    logic [2:0]  rows8;
    logic [2:0]  pr8;
    logic [11:0] addr4_0;
    logic [11:0] addr4_1;
    logic [11:0] addr8;
    logic        inr0;
    logic        inr1;
    logic        inr8;
    logic        room0;
    logic        room1;
    logic        emit0;
    logic        emit1;
    job_t        job0;
    job_t        job1;

    assign in_stall = pend_valid_reg || q_full;
    assign accept   = in_valid && !in_stall;

    // row base, clamped to the rows present
    always_comb
    begin
        live  = (32'(palette_entries) > 32'(PALETTE_DEPTH)) ? 11'(PALETTE_DEPTH)
                                                             : palette_entries;
        rows4 = live[10:4];
        rows8 = live[10:8];
        if (rows4 == 7'd0)
        begin
            pr4 = 7'd0;
        end
        else if (palette_row >= {1'b0, rows4})
        begin
            pr4 = rows4 - 7'd1;
        end
        else
        begin
            pr4 = palette_row[6:0];
        end
        if (rows8 == 3'd0)
        begin
            pr8 = 3'd0;
        end
        else if (palette_row >= {5'b0, rows8})
        begin
            pr8 = rows8 - 3'd1;
        end
        else
        begin
            pr8 = palette_row[2:0];
        end
        addr4_0 = {1'b0, pr4, 4'b0} + {8'b0, pixel_data[3:0]};
        addr4_1 = {1'b0, pr4, 4'b0} + {8'b0, pixel_data[7:4]};
        addr8   = {1'b0, pr8, 8'b0} + {4'b0, pixel_data[7:0]};
        inr0    = addr4_0 < {1'b0, live};
        inr1    = addr4_1 < {1'b0, live};
        inr8    = addr8 < {1'b0, live};
    end

    always_comb
    begin
        room0 = emitted_reg < pixel_count;
        room1 = (emitted_reg + 24'd1) < pixel_count;
        emit0 = 1'b0;
        emit1 = 1'b0;
        job0  = '0;
        job1  = '0;
        push_job        = '0;
        push            = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_job_next   = pend_job_reg;
        emitted_next    = emitted_reg;

        if (pend_valid_reg)
        begin
            push_job = pend_job_reg;
            if (!q_full)
            begin
                push            = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            unique case (cmd)
                CMD_WRITE:
                begin
                    job0.kind = JOB_WRITE;
                    job0.addr = JOB_ADDR_W'(entry_index);
                    job0.data = entry_color;
                    emit0     = 32'(entry_index) < 32'(PALETTE_DEPTH);
                    push      = emit0;
                    push_job  = job0;
                end
                CMD_NEW:
                begin
                    emitted_next = '0;
                end
                CMD_PIXEL:
                begin
                    case (pixel_mode)
                        MODE_4BPP:
                        begin
                            emit0     = room0 && inr0;
                            emit1     = (emit0 ? room1 : room0) && inr1;
                            job0.kind = JOB_LOOKUP;
                            job0.addr = JOB_ADDR_W'(addr4_0);
                            job0.last = !emit1;
                            job1.kind = JOB_LOOKUP;
                            job1.addr = JOB_ADDR_W'(addr4_1);
                            job1.last = 1'b1;
                            if (emit0)
                            begin
                                push     = 1'b1;
                                push_job = job0;
                                if (emit1)
                                begin
                                    pend_valid_next = 1'b1;
                                    pend_job_next   = job1;
                                end
                            end
                            else if (emit1)
                            begin
                                push     = 1'b1;
                                push_job = job1;
                            end
                            emitted_next = emitted_reg + 24'(emit0) + 24'(emit1);
                        end
                        MODE_8BPP:
                        begin
                            // out of range gives a zero pixel, which is a direct zero
                            job0.kind = inr8 ? JOB_LOOKUP : JOB_DIRECT;
                            job0.addr = JOB_ADDR_W'(addr8);
                            job0.last = 1'b1;
                            push      = room0;
                            push_job  = job0;
                            if (room0)
                            begin
                                emitted_next = emitted_reg + 24'd1;
                            end
                        end
                        MODE_16BPP:
                        begin
                            job0.kind = JOB_DIRECT;
                            job0.data = pixel_data;
                            job0.last = 1'b1;
                            push      = room0;
                            push_job  = job0;
                            if (room0)
                            begin
                                emitted_next = emitted_reg + 24'd1;
                            end
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            emitted_reg    <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            emitted_reg    <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_job_reg <= pend_job_next;
    end

    // a held second pixel leaves as soon as the queue has room
    a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !q_full |=> !pend_valid_reg)
        else $error("held pixel not drained");

endmodule

// ----- rtl/core/clutx_queue.sv -----
// ----------------------------------------------------------------------------
// clutx_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module clutx_queue
    import clutx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic q_valid,
    output job_t q_job,
    input  logic pop
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full    = count_reg == (PW+1)'(DEPTH);
    assign q_valid = count_reg != '0;
    assign q_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !q_valid))
        else $error("job queue underflow");

endmodule

// ----- rtl/core/clutx_back.sv -----
// ----------------------------------------------------------------------------
// clutx_back
// palette store, lookup and color expansion into the output register
// ----------------------------------------------------------------------------
module clutx_back
    import clutx_pkg::*;
#(
    parameter int PALETTE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  job_t        q_job,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] rgba_pixel,
    output logic        last_of_item
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [15:0] pal_mem [PALETTE_DEPTH];
    logic [15:0] rd_data_reg;

    logic        s1_valid_reg;
    logic        s1_lookup_reg;
    logic [15:0] s1_data_reg;
    logic        s1_last_reg;

    logic        out_valid_reg;
    logic [31:0] out_rgba_reg;
    logic        out_last_reg;

    logic        out_adv;
    logic        s1_free;
    logic        is_write;
    logic [AW-1:0] mem_addr;
    logic [15:0] s1_color;

    assign out_adv  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_free  = !s1_valid_reg || out_adv;
    assign pop      = q_valid && s1_free;
    assign is_write = q_job.kind == JOB_WRITE;
    assign mem_addr = q_job.addr[AW-1:0];
    assign s1_color = s1_lookup_reg ? rd_data_reg : s1_data_reg;

    assign out_valid    = out_valid_reg;
    assign rgba_pixel   = out_rgba_reg;
    assign last_of_item = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (pop && is_write)
        begin
            pal_mem[mem_addr] <= q_job.data;
        end
        if (pop && q_job.kind == JOB_LOOKUP)
        begin
            rd_data_reg <= pal_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= !is_write;
            end
            else if (out_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_lookup_reg <= q_job.kind == JOB_LOOKUP;
            s1_data_reg   <= q_job.data;
            s1_last_reg   <= q_job.last;
        end
        if (out_adv)
        begin
            out_rgba_reg <= expand_color(s1_color);
            out_last_reg <= s1_last_reg;
        end
    end

    // a palette write never occupies the lookup stage
    a_write_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pop && is_write |=> !s1_valid_reg)
        else $error("palette write produced a pixel");

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_adv |=> out_valid_reg)
        else $error("pixel lost between lookup and output");

endmodule

// ----- rtl/core/clut_pixel_expander_top.sv -----
// ----------------------------------------------------------------------------
// clut_pixel_expander_top
// palette pixel expander: 4bpp / 8bpp indexed or 16bpp direct to rgba8888
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   cmd, entry_index, entry_color, pixel_data
//  output    out        out_valid / out_stall rgba_pixel, last_of_item
//  config    in         apb psel/penable      paddr[3:0], pwdata, prdata
//
// one item is taken per cycle while the job queue has room, except a 4bpp
// byte whose two nibbles both produce pixels: after that item the input
// stalls while its second pixel is held, since the front pushes only one
// job into the queue at a time; from item accept to pixel on the output a
// job passes a queue slot, the lookup stage and the output register in that
// order, and a stall on the output can hold it in any of them
// reset clears control state and config registers; the palette is not cleared
// the 4-entry job queue lets the input keep flowing while the output stalls
// ----------------------------------------------------------------------------
module clut_pixel_expander_top
    import clutx_pkg::*;
#(
    parameter int PALETTE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [9:0]  entry_index,
    input  logic [15:0] entry_color,
    input  logic [15:0] pixel_data,

    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] rgba_pixel,
    output logic        last_of_item,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // register map, word addresses
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_ROW     = 2'd1;
    localparam logic [1:0] REG_ENTRIES = 2'd2;
    localparam logic [1:0] REG_COUNT   = 2'd3;

    logic [1:0]  mode_reg;
    logic [7:0]  row_reg;
    logic [10:0] entries_reg;
    logic [23:0] count_reg;

    logic        cfg_wr;
    logic        push;
    job_t        push_job;
    logic        q_full;
    logic        q_valid;
    job_t        q_job;
    logic        pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // config registers; the user must write them only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            row_reg     <= '0;
            entries_reg <= '0;
            count_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MODE:    mode_reg    <= pwdata[1:0];
                REG_ROW:     row_reg     <= pwdata[7:0];
                REG_ENTRIES: entries_reg <= pwdata[10:0];
                REG_COUNT:   count_reg   <= pwdata[23:0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:    prdata = {30'b0, mode_reg};
            REG_ROW:     prdata = {24'b0, row_reg};
            REG_ENTRIES: prdata = {21'b0, entries_reg};
            REG_COUNT:   prdata = {8'b0, count_reg};
            default:     prdata = '0;
        endcase
    end

    // front: classify items, apply row clamp and pixel budget
    clutx_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .entry_index     (entry_index),
        .entry_color     (entry_color),
        .pixel_data      (pixel_data),
        .pixel_mode      (mode_reg),
        .palette_row     (row_reg),
        .palette_entries (entries_reg),
        .pixel_count     (count_reg),
        .push            (push),
        .push_job        (push_job),
        .q_full          (q_full)
    );

    // jobs in order, palette writes included so lookups see them in sequence
    clutx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop)
    );

    // back: palette store, lookup, color expansion, output register
    clutx_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rgba_pixel   (rgba_pixel),
        .last_of_item (last_of_item)
    );

endmodule
